// File: hw/rtl/tplc_pkg.sv
package tplc_pkg;

  // Widths of the fixed fields and of the internal arithmetic.
  localparam int PT_W   = 32;  // calibration points, samples and results
  localparam int DIFF_W = 33;  // difference of two points
  localparam int MAG_W  = 32;  // magnitude of such a difference
  localparam int GAIN_W = 64;  // gain and bias in fixed point
  localparam int MUL_W  = 32;  // operand width of the shared multiplier
  localparam int WIDE_W = 98;  // product plus bias, exact
  localparam int ADDR_W = 5;   // APB byte address
  localparam int IDX_W  = 3;   // register index within the address

  // Request codes.
  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_CAL   = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EQUAL = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_RAW_LOW    = 3'd0;
  localparam logic [IDX_W-1:0] REG_RAW_HIGH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_IDEAL_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_IDEAL_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_NARROW     = 3'd4;

  typedef struct packed {
    logic                   cmd;
    logic signed [PT_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [PT_W-1:0] corrected;
    logic [1:0]             status;
  } out_item_t;

  // A calibration point as used: in narrow mode its low half, sign-extended.
  function automatic logic [PT_W-1:0] pt_narrow(input logic [PT_W-1:0] v,
                                                input logic narrow);
    logic [PT_W-1:0] r;
    r = narrow ? {{(PT_W/2){v[PT_W/2-1]}}, v[PT_W/2-1:0]} : v;
    return r;
  endfunction

endpackage

// File: hw/rtl/tplc_div.sv
// Restoring divider, one quotient bit per cycle.
module tplc_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] sub;

  // Shift the next numerator bit into the remainder and try the subtraction.
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign sub    = {1'b0, rem_sh} - {2'b00, den_q};

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The numerator register turns into the quotient bit by bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ~sub[DEN_W+1]};
      rem_q <= sub[DEN_W+1] ? rem_sh[DEN_W-1:0] : sub[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/two_point_linear_calibration_unit.sv
// Two-point linear calibration unit.
// Four points (raw_low, raw_high, ideal_low, ideal_high) and narrow_mode are
// written over the APB port at byte addresses 0, 4, 8, 12 and 16; pready is
// always high and reads return the register. Write them only while idle.
// Requests enter on in_valid_i/in_ready_o. A calibrate request derives gain
// and bias in fixed point with FRAC_BITS fraction bits; an apply request
// returns gain * raw_sample + bias, rounded half away from zero and clamped
// to 32 bits. One result per request leaves on out_valid_o/out_ready_i.
// The block takes one request at a time. An apply request passes twice
// through the shared 32x32 multiplier, once per half of the gain, and then
// through the wide adder. A calibrate request is dominated by the divider
// that yields one quotient bit per cycle; equal raw points end it before
// the divider starts.
// The output register holds a result while the receiver stalls; a new
// request is taken meanwhile and the block waits at its last step until the
// register is free. Reset sets gain to one, bias and the config to zero.
module two_point_linear_calibration_unit #(
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tplc_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tplc_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tplc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int PT_W   = tplc_pkg::PT_W;
  localparam int DIFF_W = tplc_pkg::DIFF_W;
  localparam int MAG_W  = tplc_pkg::MAG_W;
  localparam int GAIN_W = tplc_pkg::GAIN_W;
  localparam int MUL_W  = tplc_pkg::MUL_W;
  localparam int WIDE_W = tplc_pkg::WIDE_W;
  localparam int NUM_W  = MAG_W + 1 + FRAC_BITS;

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_CAL_DIFF  = 15'b000000000000010,
    S_CAL_ABS   = 15'b000000000000100,
    S_DIV_START = 15'b000000000001000,
    S_DIV_WAIT  = 15'b000000000010000,
    S_MSET      = 15'b000000000100000,
    S_MUL_LO    = 15'b000000001000000,
    S_MUL_HI    = 15'b000000010000000,
    S_ACCUM     = 15'b000000100000000,
    S_NEGATE    = 15'b000001000000000,
    S_ADDEND    = 15'b000010000000000,
    S_SAT       = 15'b000100000000000,
    S_ABS       = 15'b001000000000000,
    S_ROUND     = 15'b010000000000000,
    S_FIN       = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [PT_W-1:0] raw_low_q, raw_high_q, ideal_low_q, ideal_high_q;
  logic            narrow_q;

  logic [GAIN_W-1:0] gain_q, bias_q;
  logic              cal_q;
  logic [PT_W-1:0]   sample_q;
  logic [DIFF_W-1:0] dx_q, dy_q;
  logic [MAG_W-1:0]  udx_q, udy_q;
  logic              gneg_q;
  logic [GAIN_W-1:0] mag_q;
  logic [MUL_W-1:0]  mop_q;
  logic              pneg_q;
  logic [2*MUL_W-1:0] mul_q;
  logic [WIDE_W-1:0] acc_q;
  logic              neg_q;

  logic                out_valid_q;
  tplc_pkg::out_item_t out_data_q;

  logic [PT_W-1:0]     rl_n, rh_n, il_n, ih_n;
  logic                cfg_wr;
  logic                out_free;
  logic                load_en;
  tplc_pkg::out_item_t load_data;
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    div_num;
  logic [NUM_W-1:0]    div_quo;
  logic [MUL_W-1:0]    mul_a;
  logic [2*MUL_W-1:0]  mul_p;
  logic [PT_W-1:0]     mset_r;
  logic [GAIN_W-1:0]   addend;
  logic [GAIN_W-1:0]   bias_sat;
  logic [WIDE_W-1:0]   fin_quo, fin_limit;
  logic                fin_sat;
  logic [PT_W-1:0]     fin_mag;

  // Configuration registers.
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q    <= '0;
      raw_high_q   <= '0;
      ideal_low_q  <= '0;
      ideal_high_q <= '0;
      narrow_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[tplc_pkg::ADDR_W-1:2])
        tplc_pkg::REG_RAW_LOW:    raw_low_q    <= pwdata;
        tplc_pkg::REG_RAW_HIGH:   raw_high_q   <= pwdata;
        tplc_pkg::REG_IDEAL_LOW:  ideal_low_q  <= pwdata;
        tplc_pkg::REG_IDEAL_HIGH: ideal_high_q <= pwdata;
        tplc_pkg::REG_NARROW:     narrow_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[tplc_pkg::ADDR_W-1:2])
      tplc_pkg::REG_RAW_LOW:    prdata = raw_low_q;
      tplc_pkg::REG_RAW_HIGH:   prdata = raw_high_q;
      tplc_pkg::REG_IDEAL_LOW:  prdata = ideal_low_q;
      tplc_pkg::REG_IDEAL_HIGH: prdata = ideal_high_q;
      tplc_pkg::REG_NARROW:     prdata = {31'b0, narrow_q};
      default:                  prdata = '0;
    endcase
  end

  // Points as the arithmetic sees them.
  assign rl_n = tplc_pkg::pt_narrow(raw_low_q, narrow_q);
  assign rh_n = tplc_pkg::pt_narrow(raw_high_q, narrow_q);
  assign il_n = tplc_pkg::pt_narrow(ideal_low_q, narrow_q);
  assign ih_n = tplc_pkg::pt_narrow(ideal_high_q, narrow_q);

  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    load_en   = 1'b0;
    load_data = '0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.cmd == tplc_pkg::CMD_CAL) ? S_CAL_DIFF : S_MSET;
        end
      end
      S_CAL_DIFF: state_d = S_CAL_ABS;
      S_CAL_ABS: begin
        if (dx_q == '0) begin
          if (out_free) begin
            load_en          = 1'b1;
            load_data.status = tplc_pkg::ST_EQUAL;
            state_d          = S_IDLE;
          end
        end else begin
          state_d = S_DIV_START;
        end
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_MSET;
        end
      end
      S_MSET:   state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_ACCUM;
      S_ACCUM:  state_d = S_NEGATE;
      S_NEGATE: state_d = S_ADDEND;
      S_ADDEND: state_d = cal_q ? S_SAT : S_ABS;
      S_SAT: begin
        if (out_free) begin
          load_en          = 1'b1;
          load_data.status = tplc_pkg::ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_ABS:   state_d = S_ROUND;
      S_ROUND: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          load_en             = 1'b1;
          load_data.corrected = neg_q ? -fin_mag : fin_mag;
          load_data.status    = fin_sat ? tplc_pkg::ST_SAT : tplc_pkg::ST_OK;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider for the gain quotient.
  assign div_num = (NUM_W'(udy_q) << FRAC_BITS) + NUM_W'(udx_q >> 1);

  tplc_div #(
    .NUM_W(NUM_W),
    .DEN_W(MAG_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (udx_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Shared 32x32 multiplier, one half of the gain magnitude per pass.
  assign mul_a = (state_q == S_MUL_LO) ? mag_q[MUL_W-1:0] : mag_q[GAIN_W-1:MUL_W];
  assign mul_p = mul_a * mop_q;

  // Multiplier operand: raw_low on calibrate, the sample on apply.
  assign mset_r = cal_q ? rl_n : sample_q;

  // Term added to the signed product: ideal_low in fixed point, or the bias.
  assign addend = cal_q ? ({{(GAIN_W-PT_W){il_n[PT_W-1]}}, il_n} << FRAC_BITS) : bias_q;

  // Bias clamped to the signed 64-bit range.
  always_comb begin
    if (acc_q[WIDE_W-1:GAIN_W-1] == '0 || acc_q[WIDE_W-1:GAIN_W-1] == '1) begin
      bias_sat = acc_q[GAIN_W-1:0];
    end else begin
      bias_sat = {acc_q[WIDE_W-1], {(GAIN_W-1){~acc_q[WIDE_W-1]}}};
    end
  end

  // Integer part of the rounded magnitude, clamped to the 32-bit limit.
  assign fin_quo   = acc_q >> FRAC_BITS;
  assign fin_limit = neg_q ? (WIDE_W'(1) << (PT_W - 1))
                           : ((WIDE_W'(1) << (PT_W - 1)) - WIDE_W'(1));
  assign fin_sat   = (fin_quo > fin_limit);
  assign fin_mag   = fin_sat ? fin_limit[PT_W-1:0] : fin_quo[PT_W-1:0];

  // Gain and bias, with their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(1) << FRAC_BITS;
      bias_q <= '0;
    end else begin
      if (state_q == S_DIV_WAIT && div_done) begin
        gain_q <= gneg_q ? -GAIN_W'(div_quo) : GAIN_W'(div_quo);
      end
      if (state_q == S_SAT && out_free) begin
        bias_q <= bias_sat;
      end
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cal_q    <= in_data_i.cmd;
          sample_q <= in_data_i.raw_sample;
        end
      end
      S_CAL_DIFF: begin
        dx_q <= {rh_n[PT_W-1], rh_n} - {rl_n[PT_W-1], rl_n};
        dy_q <= {ih_n[PT_W-1], ih_n} - {il_n[PT_W-1], il_n};
      end
      S_CAL_ABS: begin
        udx_q  <= dx_q[DIFF_W-1] ? MAG_W'(-dx_q) : dx_q[MAG_W-1:0];
        udy_q  <= dy_q[DIFF_W-1] ? MAG_W'(-dy_q) : dy_q[MAG_W-1:0];
        gneg_q <= dx_q[DIFF_W-1] ^ dy_q[DIFF_W-1];
      end
      S_MSET: begin
        mag_q  <= gain_q[GAIN_W-1] ? -gain_q : gain_q;
        mop_q  <= mset_r[PT_W-1] ? -mset_r : mset_r;
        // On calibrate the product is subtracted from the base.
        pneg_q <= gain_q[GAIN_W-1] ^ mset_r[PT_W-1] ^ cal_q;
      end
      S_MUL_LO: mul_q <= mul_p;
      S_MUL_HI: begin
        acc_q <= WIDE_W'(mul_q);
        mul_q <= mul_p;
      end
      S_ACCUM: acc_q <= acc_q + (WIDE_W'(mul_q) << MUL_W);
      S_NEGATE: begin
        if (pneg_q) begin
          acc_q <= -acc_q;
        end
      end
      S_ADDEND: acc_q <= acc_q + {{(WIDE_W-GAIN_W){addend[GAIN_W-1]}}, addend};
      S_ABS: begin
        neg_q <= acc_q[WIDE_W-1];
        acc_q <= acc_q[WIDE_W-1] ? -acc_q : acc_q;
      end
      S_ROUND: acc_q <= acc_q + (WIDE_W'(1) << (FRAC_BITS - 1));
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      out_data_q <= load_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hw/rtl/tplc_chk.sv
// Port-level checks for the calibration unit.
module tplc_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input tplc_pkg::out_item_t         out_data_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The unit works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // Equal raw points give a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == tplc_pkg::ST_EQUAL |-> out_data_o.corrected == '0)
    else $error("nonzero result on equal raw points");

  // A saturated result sits at one of the 32-bit limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == tplc_pkg::ST_SAT |->
      out_data_o.corrected == 32'sh7fffffff || out_data_o.corrected == 32'sh80000000)
    else $error("saturated result not at a limit");

endmodule

bind two_point_linear_calibration_unit tplc_chk u_tplc_chk (.*);
